@@ rtl/arc_pkg.sv @@
`default_nettype none

package arc_pkg;

   localparam int MAX_RESULTS = 4;
   localparam logic [7:0] HYPHEN_CHAR = 8'h2D;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_run_last;
      logic       out_string_end;
   } rsp_entry_type;

   // results caused by one input item, entry 0 leaves first
   typedef struct packed {
      rsp_entry_type [MAX_RESULTS-1:0] entry;
      logic [2:0]                      count;
   } burst_type;

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) ||
             (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

`default_nettype wire

@@ rtl/arc_run_tracker.sv @@
`default_nettype none

module arc_run_tracker (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_char,
   input  logic              in_last,
   output arc_pkg::burst_type burst
);
   import arc_pkg::*;

   logic [7:0] run_first_ff, run_first_in;
   logic [7:0] run_latest_ff, run_latest_in;
   logic [1:0] run_length_ff, run_length_in;

   logic       alnum;
   logic       extend;
   logic [1:0] ext_length;
   logic [7:0] fl_first;
   logic [7:0] fl_latest;
   logic [1:0] fl_length;
   logic       x_en;
   logic [2:0] fl_count;
   logic [1:0] tail;

   always_comb begin
      alnum      = is_alnum(in_char);
      extend     = alnum && (run_length_ff != 2'd0) &&
                   ({1'b0, in_char} == ({1'b0, run_latest_ff} + 9'd1));
      ext_length = (run_length_ff == 2'd3) ? 2'd3 : run_length_ff + 2'd1;

      run_first_in  = run_first_ff;
      run_latest_in = run_latest_ff;
      run_length_in = run_length_ff;
      fl_first      = run_first_ff;
      fl_latest     = run_latest_ff;
      fl_length     = run_length_ff;
      x_en          = 1'b0;

      if (extend) begin
         // grow the run; flush it only at end of string
         run_latest_in = in_char;
         run_length_in = ext_length;
         fl_latest     = in_char;
         fl_length     = in_last ? ext_length : 2'd0;
      end else if (alnum) begin
         run_first_in  = in_char;
         run_latest_in = in_char;
         run_length_in = 2'd1;
         x_en          = in_last;
      end else begin
         run_length_in = 2'd0;
         x_en          = 1'b1;
      end

      if (in_last) begin
         run_first_in  = 8'd0;
         run_latest_in = 8'd0;
         run_length_in = 2'd0;
      end

      burst = '0;
      case (fl_length)
         2'd1: begin
            burst.entry[0].out_char = fl_first;
         end
         2'd2: begin
            burst.entry[0].out_char = fl_first;
            burst.entry[1].out_char = fl_latest;
         end
         2'd3: begin
            burst.entry[0].out_char = fl_first;
            burst.entry[1].out_char = HYPHEN_CHAR;
            burst.entry[2].out_char = fl_latest;
         end
         default: begin
         end
      endcase

      fl_count = {1'b0, fl_length};
      if (x_en) begin
         burst.entry[fl_count[1:0]].out_char = in_char;
      end
      burst.count = fl_count + {2'b00, x_en};
      tail        = 2'(burst.count - 3'd1);
      if (burst.count != 3'd0) begin
         burst.entry[tail].out_run_last   = 1'b1;
         burst.entry[tail].out_string_end = in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_first_ff  <= 8'd0;
         run_latest_ff <= 8'd0;
         run_length_ff <= 2'd0;
      end else if (accept) begin
         run_first_ff  <= run_first_in;
         run_latest_ff <= run_latest_in;
         run_length_ff <= run_length_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/arc_result_queue.sv @@
`default_nettype none

module arc_result_queue #(
   parameter int DEPTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  arc_pkg::burst_type     burst,
   output logic                   room,
   input  logic                   pop,
   output logic                   head_valid,
   output arc_pkg::rsp_entry_type head
);
   import arc_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   rsp_entry_type [DEPTH-1:0] slot_ff, slot_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             base;

   assign base       = count_ff - CW'(pop);
   assign room       = count_ff <= CW'(DEPTH - MAX_RESULTS);
   assign head_valid = count_ff != '0;
   assign head       = slot_ff[0];
   assign count_in   = base + (push ? CW'(burst.count) : CW'(0));

   // shift toward the head on pop, append the burst behind what remains
   for (genvar j = 0; j < DEPTH; j++) begin : g_slot
      localparam int NXT = (j + 1 < DEPTH) ? j + 1 : j;
      logic [CW-1:0] pos;
      logic [CW-1:0] off;
      assign pos = CW'(j);
      assign off = pos - base;
      always_comb begin
         slot_in[j] = slot_ff[j];
         if (pos < base) begin
            slot_in[j] = pop ? slot_ff[NXT] : slot_ff[j];
         end else if (push && off < CW'(burst.count)) begin
            slot_in[j] = burst.entry[off[1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/alnum_run_contractor_unit.sv @@
// A result reaches rsp_ through the registered queue in the cycle after its
// input transfer at the earliest; characters queued ahead of it leave first.
// One input transfer per cycle while the queue holds at most QUEUE_DEPTH-4
// characters; results leave one per cycle while rsp_ready is high, so flush
// bursts of up to four characters stall the input side briefly. Reset
// (synchronous, active high) closes any open run and empties the queue.
`default_nettype none

module alnum_run_contractor_unit #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_char,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_run_last,
   output logic       rsp_out_string_end
);
   import arc_pkg::*;

   logic          req_fire;
   logic          rsp_fire;
   logic          room;
   burst_type     burst;
   rsp_entry_type head;

   // accept only when the queue can absorb a worst-case burst; room comes
   // from the registered fill count alone, so the two sides stay decoupled
   assign req_ready = room;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // run state plus the burst of characters this transfer releases
   arc_run_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_fire),
      .in_char (req_in_char),
      .in_last (req_in_last),
      .burst   (burst)
   );

   // hold results until the consumer takes them, head entry drives rsp_
   arc_result_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_fire),
      .burst      (burst),
      .room       (room),
      .pop        (rsp_fire),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign rsp_out_char       = head.out_char;
   assign rsp_out_run_last   = head.out_run_last;
   assign rsp_out_string_end = head.out_string_end;

endmodule

`default_nettype wire

@@ rtl/arc_checker.sv @@
`default_nettype none

module arc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_in_char,
   input logic       req_in_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_out_run_last,
   input logic       rsp_out_string_end
);

   // a result must not vanish or change before transfer
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) &&
      $stable(rsp_out_run_last) && $stable(rsp_out_string_end))
      else $error("rsp transfer dropped or changed before acceptance");

   // string end only ever marks the last character of an item
   a_end_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_string_end |-> rsp_out_run_last)
      else $error("string end without run last");

   // a space character with last, taken while no result waits, always ends its string at once
   a_punct_last : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_in_last && req_in_char == 8'h20 && !rsp_valid
      |=> rsp_valid)
      else $error("no result after last-character transfer");

   // empty and ready straight out of reset
   a_reset_state : assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("not idle after reset");

endmodule

bind alnum_run_contractor_unit arc_checker u_arc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_in_char        (req_in_char),
   .req_in_last        (req_in_last),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_out_char       (rsp_out_char),
   .rsp_out_run_last   (rsp_out_run_last),
   .rsp_out_string_end (rsp_out_string_end)
);

`default_nettype wire

@@ verif/alnum_run_contractor_unit_tb.sv @@
`timescale 1ns / 1ps

module alnum_run_contractor_unit_tb;
   import arc_pkg::*;

   // Tracks the contraction of the character stream and holds the characters
   // that the block still owes on its result channel.
   class char_scoreboard;
      logic [7:0]    run_first = 8'h00;
      logic [7:0]    run_latest = 8'h00;
      logic [1:0]    run_length = 2'd0;
      rsp_entry_type burst[MAX_RESULTS];
      int            burst_len = 0;
      rsp_entry_type pending_chars[$];
      int            mismatches = 0;
      int            strings_seen = 0;
      int            hyphen_runs = 0;
      int            chars_checked = 0;

      function automatic logic is_alnum_code(logic [7:0] c);
         return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
      endfunction

      function void put_char(logic [7:0] c);
         burst[burst_len].out_char       = c;
         burst[burst_len].out_run_last   = 1'b0;
         burst[burst_len].out_string_end = 1'b0;
         burst_len++;
      endfunction

      function void flush_run();
         if (run_length != 2'd0) put_char(run_first);
         if (run_length == 2'd2) put_char(run_latest);
         if (run_length == 2'd3) begin
            put_char(HYPHEN_CHAR);
            put_char(run_latest);
            hyphen_runs++;
         end
         run_length = 2'd0;
      endfunction

      function void absorb_char(logic [7:0] c, logic is_last);
         burst_len = 0;
         if (is_alnum_code(c)) begin
            if (run_length != 2'd0 && {1'b0, c} == {1'b0, run_latest} + 9'd1) begin
               run_latest = c;
               if (run_length != 2'd3) run_length = run_length + 2'd1;
            end else begin
               flush_run();
               run_first  = c;
               run_latest = c;
               run_length = 2'd1;
            end
         end else begin
            flush_run();
            put_char(c);
         end
         if (is_last) begin
            flush_run();
            run_first  = 8'h00;
            run_latest = 8'h00;
            strings_seen++;
         end
         if (burst_len > 0) begin
            burst[burst_len-1].out_run_last   = 1'b1;
            burst[burst_len-1].out_string_end = is_last;
         end
         for (int i = 0; i < burst_len; i++) pending_chars.push_back(burst[i]);
      endfunction

      function void compare_char(logic [7:0] c, logic run_last, logic string_end);
         rsp_entry_type want;
         chars_checked++;
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected result, char %h run_last %b string_end %b",
                     $time, c, run_last, string_end);
            mismatches++;
            return;
         end
         want = pending_chars.pop_front();
         if (c !== want.out_char) begin
            $display("%0t: out_char expected %h actual %h", $time, want.out_char, c);
            mismatches++;
         end
         if (run_last !== want.out_run_last) begin
            $display("%0t: out_run_last expected %b actual %b",
                     $time, want.out_run_last, run_last);
            mismatches++;
         end
         if (string_end !== want.out_string_end) begin
            $display("%0t: out_string_end expected %b actual %b",
                     $time, want.out_string_end, string_end);
            mismatches++;
         end
      endfunction
   endclass

   localparam int RANDOM_CHARS = 100;
   localparam int IDLE_LIMIT   = 4000;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 8;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_char;
   logic       req_in_last;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_char;
   logic       rsp_out_run_last;
   logic       rsp_out_string_end;

   char_scoreboard sb;
   logic [7:0]     text_buf[$];
   int             src_idle_pct = 18;
   int             sink_idle_pct = 55;
   int             chars_sent = 0;
   bit             hold_request = 1'b0;
   bit             hold_done = 1'b0;

   alnum_run_contractor_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_char        (req_in_char),
      .req_in_last        (req_in_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_char       (rsp_out_char),
      .rsp_out_run_last   (rsp_out_run_last),
      .rsp_out_string_end (rsp_out_string_end)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offer one character and hold it until the block takes the transfer.
   // Valid is only lowered when an idle cycle is drawn, so back-to-back
   // transfers never see valid dropped and raised in the same step.
   task automatic send_char(input logic [7:0] c, input logic is_last);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_char <= c;
      req_in_last <= is_last;
      do @(posedge clock); while (!req_ready);
      sb.absorb_char(c, is_last);
      chars_sent++;
   endtask

   // Send the buffered string, flag its final character, then empty the buffer.
   task automatic send_text_buf();
      for (int i = 0; i < text_buf.size(); i++)
         send_char(text_buf[i], i == text_buf.size() - 1);
      text_buf.delete();
   endtask

   task automatic buffer_text(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   // Build one random string: mostly ascending alphanumeric runs of random
   // start and length, mixed with punctuation and arbitrary bytes as noise.
   task automatic buffer_random_string();
      int         pieces;
      int         run_len;
      int         pick;
      logic [7:0] base;
      logic [7:0] span;
      logic [7:0] c;
      pieces = $urandom_range(1, 4);
      for (int p = 0; p < pieces; p++) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            case ($urandom_range(2))
               0: begin base = "0"; span = 8'd10; end
               1: begin base = "A"; span = 8'd26; end
               default: begin base = "a"; span = 8'd26; end
            endcase
            c       = base + 8'($urandom_range(span - 1));
            run_len = $urandom_range(1, 6);
            // stop at the end of the class so the run breaks there naturally
            for (int k = 0; k < run_len && c < base + span; k++) begin
               text_buf.push_back(c);
               c = c + 8'd1;
            end
         end else if (pick < 85) begin
            text_buf.push_back(8'($urandom_range(8'h20, 8'h2F)));
         end else begin
            text_buf.push_back(8'($urandom_range(255)));
         end
      end
   endtask

   // Result side: random back-pressure, plus one long hold-off on request so
   // that the result queue fills and the block must stall its input.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   // Check every result transfer against the oldest outstanding character.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.compare_char(rsp_out_char, rsp_out_run_last, rsp_out_string_end);
   end

   // End the run if neither channel completes a transfer for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      sb = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_in_char <= 8'h00;
      req_in_last <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed strings: a saturating run ended by punctuation, the class
      // boundaries after 'z', '9' and 'Z', bytes above 127 and zero, a lone
      // character, a pair flushed by the end of string, and a long run
      // broken by a new run that the end of string flushes at once.
      buffer_text("abcd!");
      send_text_buf();
      buffer_text("xyz{");
      send_text_buf();
      buffer_text("89:");
      send_text_buf();
      buffer_text("YZ[");
      send_text_buf();
      text_buf.push_back(8'h00);
      text_buf.push_back(8'h80);
      text_buf.push_back(8'hFF);
      send_text_buf();
      buffer_text("Q");
      send_text_buf();
      buffer_text("01");
      send_text_buf();
      buffer_text("abcX");
      send_text_buf();

      // Random strings in three idling phases; the long hold-off lands at the
      // start of the phase with no idling, where the sender offers every cycle.
      while (chars_sent < 25 + RANDOM_CHARS) begin
         if (chars_sent >= 25 + 2 * RANDOM_CHARS / 3) begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
            hold_request  = 1'b1;
         end else if (chars_sent >= 25 + RANDOM_CHARS / 3) begin
            src_idle_pct  = 55;
            sink_idle_pct = 18;
         end
         buffer_random_string();
         send_text_buf();
      end
      req_valid <= 1'b0;

      // Drain outstanding characters, then allow a few cycles for strays.
      while (sb.pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d characters in %0d strings; checked %0d result characters,",
               chars_sent, sb.strings_seen, sb.chars_checked);
      $display("%0d runs contracted with a hyphen, %0d mismatches",
               sb.hyphen_runs, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
